[hdl/hwc_pkg.sv]
// shared types and constants for the haptic wall current controller
package hwc_pkg;

    // control modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_OPEN   = 3'd1;
    localparam logic [2:0] MODE_STEP   = 3'd2;
    localparam logic [2:0] MODE_HOLD   = 3'd3;
    localparam logic [2:0] MODE_HAPTIC = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_KP    = 3'd1;
    localparam logic [2:0] REG_KI    = 3'd2;
    localparam logic [2:0] REG_OPEN  = 3'd3;
    localparam logic [2:0] REG_LEFT  = 3'd4;
    localparam logic [2:0] REG_RIGHT = 3'd5;
    localparam logic [2:0] REG_STIFF = 3'd6;

    // shared multiplier operand selects
    localparam logic [2:0] MUL_WALL  = 3'd0;
    localparam logic [2:0] MUL_KP    = 3'd1;
    localparam logic [2:0] MUL_KI    = 3'd2;
    localparam logic [2:0] MUL_LVL   = 3'd3;
    localparam logic [2:0] MUL_RECIP = 3'd4;

    // duty register load selects
    localparam logic [1:0] DUTY_KEEP = 2'd0;
    localparam logic [1:0] DUTY_ZERO = 2'd1;
    localparam logic [1:0] DUTY_OPEN = 2'd2;
    localparam logic [1:0] DUTY_PI   = 2'd3;

    // fixed-point limits
    localparam logic signed [16:0] DUTY_FULL        = 17'sd25600;
    localparam logic [11:0]        SUPPLY_LOW       = 12'd50;
    localparam logic [11:0]        SUPPLY_HIGH      = 12'd2000;
    localparam logic signed [25:0] HAPTIC_SUM_LIMIT = 26'sd80000;
    localparam logic signed [25:0] SUM_MAX          = 26'sd8388607;
    localparam logic signed [25:0] SUM_MIN          = -26'sd8388608;
    localparam logic signed [16:0] TEST_AMPLITUDE   = 17'sd1600;
    localparam logic [12:0]        ANGLE_MIN_FREE   = 13'd8;
    localparam logic [12:0]        ANGLE_HALF       = 13'd2880;
    localparam logic signed [47:0] TARGET_MAX       = 48'sd65535;
    localparam logic signed [47:0] TARGET_MIN       = -48'sd65536;
    localparam logic [41:0]        ROUND_HALF       = 42'd2048;

    // floor(y / 100) = (y * DIV100_RECIP) >> DIV100_SHIFT, exact for y below 2^23
    localparam logic [23:0] DIV100_RECIP = 24'd10737419;
    localparam int          DIV100_SHIFT = 30;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       check;
        logic       step_tick;
        logic       test_end;
        logic       wall_sat;
        logic       err_upd;
        logic       sum_haptic;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       pi_round;
        logic [1:0] duty_sel;
        logic       lvl_prep;
        logic       lvl_set;
        logic       out_load;
    } hwc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic       fault;
        logic [2:0] mode;
        logic       test_over;
        logic       out_free;
    } hwc_stat_t;

endpackage

[hdl/hwc_if.sv]
// valid/ready channel interfaces for tick samples and drive results
interface hwc_in_if;
    logic               valid;
    logic               ready;
    logic [11:0]        supply_sense;
    logic signed [16:0] measured_current;
    logic [12:0]        shaft_angle;

    modport source (output valid, output supply_sense, output measured_current,
                    output shaft_angle, input ready);
    modport sink (input valid, input supply_sense, input measured_current,
                  input shaft_angle, output ready);
endinterface

interface hwc_out_if;
    logic               valid;
    logic               ready;
    logic [12:0]        drive_level_a;
    logic [12:0]        drive_level_b;
    logic signed [15:0] duty_command;
    logic signed [16:0] target_current;
    logic               fault;
    logic               sequence_done;

    modport source (output valid, output drive_level_a, output drive_level_b,
                    output duty_command, output target_current, output fault,
                    output sequence_done, input ready);
    modport sink (input valid, input drive_level_a, input drive_level_b,
                  input duty_command, input target_current, input fault,
                  input sequence_done, output ready);
endinterface

[hdl/hwc_ctrl.sv]
// sequencing state machine for one control tick
module hwc_ctrl
    import hwc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hwc_stat_t stat,
    output hwc_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CHECK    = 4'd1;
    localparam logic [3:0] ST_WALL_MUL = 4'd2;
    localparam logic [3:0] ST_WALL_SAT = 4'd3;
    localparam logic [3:0] ST_ERR      = 4'd4;
    localparam logic [3:0] ST_PI_P     = 4'd5;
    localparam logic [3:0] ST_PI_I     = 4'd6;
    localparam logic [3:0] ST_PI_SUM   = 4'd7;
    localparam logic [3:0] ST_PI_RND   = 4'd8;
    localparam logic [3:0] ST_PI_SAT   = 4'd9;
    localparam logic [3:0] ST_LVL_PREP = 4'd10;
    localparam logic [3:0] ST_LVL_MUL  = 4'd11;
    localparam logic [3:0] ST_LVL_DIV  = 4'd12;
    localparam logic [3:0] ST_LVL_SET  = 4'd13;
    localparam logic [3:0] ST_OUT      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                priority if (stat.fault)
                begin
                    cmd.duty_sel = DUTY_ZERO;
                    state_next   = ST_LVL_PREP;
                end
                else
                begin
                    unique case (stat.mode)
                        MODE_OPEN:
                        begin
                            cmd.duty_sel = DUTY_OPEN;
                            state_next   = ST_LVL_PREP;
                        end
                        MODE_STEP:
                        begin
                            if (stat.test_over)
                            begin
                                cmd.test_end = 1'b1;
                                state_next   = ST_OUT;
                            end
                            else
                            begin
                                cmd.step_tick = 1'b1;
                                state_next    = ST_ERR;
                            end
                        end
                        MODE_HOLD:
                        begin
                            state_next = ST_OUT;
                        end
                        MODE_HAPTIC:
                        begin
                            state_next = ST_WALL_MUL;
                        end
                        default:
                        begin
                            cmd.duty_sel = DUTY_ZERO;
                            state_next   = ST_LVL_PREP;
                        end
                    endcase
                end
            end
            ST_WALL_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WALL;
                state_next  = ST_WALL_SAT;
            end
            ST_WALL_SAT:
            begin
                cmd.wall_sat = 1'b1;
                state_next   = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err_upd    = 1'b1;
                cmd.sum_haptic = (stat.mode == MODE_HAPTIC);
                state_next     = ST_PI_P;
            end
            ST_PI_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KP;
                state_next  = ST_PI_I;
            end
            ST_PI_I:
            begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_KI;
                state_next   = ST_PI_SUM;
            end
            ST_PI_SUM:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_PI_RND;
            end
            ST_PI_RND:
            begin
                cmd.pi_round = 1'b1;
                state_next   = ST_PI_SAT;
            end
            ST_PI_SAT:
            begin
                cmd.duty_sel = DUTY_PI;
                state_next   = ST_LVL_PREP;
            end
            ST_LVL_PREP:
            begin
                cmd.lvl_prep = 1'b1;
                state_next   = ST_LVL_MUL;
            end
            ST_LVL_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LVL;
                state_next  = ST_LVL_DIV;
            end
            ST_LVL_DIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RECIP;
                state_next  = ST_LVL_SET;
            end
            ST_LVL_SET:
            begin
                cmd.lvl_set = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/hwc_datapath.sv]
// registers, config, shared multiplier and arithmetic of the current loop
module hwc_datapath
    import hwc_pkg::*;
#(
    parameter int PWM_TOP        = 7500,
    parameter int TEST_LENGTH    = 400,
    parameter int SEGMENT_LENGTH = 100
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [11:0]        supply_sense,
    input  logic signed [16:0] measured_current,
    input  logic [12:0]        shaft_angle,
    input  hwc_cmd_t           cmd,
    output hwc_stat_t          stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [12:0]        drive_level_a,
    output logic [12:0]        drive_level_b,
    output logic signed [15:0] duty_command,
    output logic signed [16:0] target_current,
    output logic               fault,
    output logic               sequence_done
);

    localparam int CNT_W = $clog2(TEST_LENGTH + 1);
    localparam int SEG_W = $clog2(SEGMENT_LENGTH + 1);
    localparam logic [CNT_W-1:0] TEST_END = CNT_W'(TEST_LENGTH);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENT_LENGTH - 1);
    localparam logic [15:0]      TOP16    = 16'(PWM_TOP);

    // configuration registers
    logic [2:0]         mode_reg;
    logic [15:0]        kp_reg;
    logic [15:0]        ki_reg;
    logic signed [15:0] open_reg;
    logic [12:0]        left_reg;
    logic [12:0]        right_reg;
    logic [7:0]         stiff_reg;

    // loop state
    logic signed [23:0] sum_reg;
    logic [CNT_W-1:0]   step_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic               phase_reg;
    logic               fin_reg;
    logic [12:0]        held_a_reg;
    logic [12:0]        held_b_reg;
    logic signed [15:0] held_duty_reg;
    logic               out_valid_reg;

    // per-tick working registers
    logic [11:0]        supply_reg;
    logic signed [16:0] meas_reg;
    logic [12:0]        angle_reg;
    logic               fault_reg;
    logic signed [16:0] target_reg;
    logic signed [14:0] pen_reg;
    logic signed [17:0] err_reg;
    logic signed [47:0] prod_reg;
    logic signed [41:0] acc_reg;
    logic [41:0]        mag_reg;
    logic               neg_reg;
    logic signed [15:0] duty_reg;
    logic [14:0]        comp_reg;

    // result register
    logic [12:0]        out_a_reg;
    logic [12:0]        out_b_reg;
    logic signed [15:0] out_duty_reg;
    logic signed [16:0] out_target_reg;
    logic               out_fault_reg;
    logic               out_done_reg;

    // combinational values
    logic               fault_w;
    logic signed [14:0] r_diff;
    logic signed [14:0] l_diff;
    logic signed [14:0] pen_w;
    logic signed [17:0] err_w;
    logic signed [25:0] sum_w;
    logic signed [25:0] sum_lo;
    logic signed [25:0] sum_hi;
    logic signed [23:0] sum_sat;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [16:0] wall_target;
    logic [29:0]        pi_q;
    logic [14:0]        pi_q_sat;
    logic signed [15:0] pi_duty;
    logic signed [15:0] open_sat;
    logic signed [16:0] duty_ext;
    logic signed [16:0] comp_w;
    logic [15:0]        lvl_w;

    // supply window check
    assign fault_w = (supply_reg < SUPPLY_LOW) || (supply_reg > SUPPLY_HIGH);

    // wall penetration, signed so that stiffness times it is the target
    assign r_diff = $signed({2'b00, right_reg}) - $signed({2'b00, angle_reg});
    assign l_diff = $signed({2'b00, left_reg}) - $signed({2'b00, angle_reg});

    always_comb
    begin
        pen_w = '0;
        if ((angle_reg > ANGLE_MIN_FREE) && (angle_reg < ANGLE_HALF))
        begin
            if (r_diff < 0)
            begin
                pen_w = r_diff;
            end
        end
        else if (angle_reg >= ANGLE_HALF)
        begin
            if (l_diff > 0)
            begin
                pen_w = l_diff;
            end
        end
    end

    // error and saturated integral
    assign err_w  = {target_reg[16], target_reg} - {meas_reg[16], meas_reg};
    assign sum_w  = {{2{sum_reg[23]}}, sum_reg} + {{8{err_w[17]}}, err_w};
    assign sum_lo = cmd.sum_haptic ? -HAPTIC_SUM_LIMIT : SUM_MIN;
    assign sum_hi = cmd.sum_haptic ? HAPTIC_SUM_LIMIT : SUM_MAX;

    always_comb
    begin
        priority if (sum_w < sum_lo)
        begin
            sum_sat = sum_lo[23:0];
        end
        else if (sum_w > sum_hi)
        begin
            sum_sat = sum_hi[23:0];
        end
        else
        begin
            sum_sat = sum_w[23:0];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_WALL:
            begin
                mul_a = $signed({17'b0, stiff_reg});
                mul_b = {{10{pen_reg[14]}}, pen_reg};
            end
            MUL_KP:
            begin
                mul_a = $signed({9'b0, kp_reg});
                mul_b = {{7{err_reg[17]}}, err_reg};
            end
            MUL_KI:
            begin
                mul_a = $signed({9'b0, ki_reg});
                mul_b = {sum_reg[23], sum_reg};
            end
            MUL_LVL:
            begin
                mul_a = $signed({10'b0, comp_reg});
                mul_b = $signed({9'b0, TOP16});
            end
            MUL_RECIP:
            begin
                mul_a = $signed({2'b0, prod_reg[30:8]});
                mul_b = $signed({1'b0, DIV100_RECIP});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // wall target saturated to the target field
    always_comb
    begin
        priority if (prod_reg < TARGET_MIN)
        begin
            wall_target = TARGET_MIN[16:0];
        end
        else if (prod_reg > TARGET_MAX)
        begin
            wall_target = TARGET_MAX[16:0];
        end
        else
        begin
            wall_target = prod_reg[16:0];
        end
    end

    // pi duty from rounded magnitude, saturated to full scale
    assign pi_q     = mag_reg[41:12];
    assign pi_q_sat = (pi_q > 30'(DUTY_FULL)) ? DUTY_FULL[14:0] : pi_q[14:0];
    assign pi_duty  = neg_reg ? -$signed({1'b0, pi_q_sat}) : $signed({1'b0, pi_q_sat});

    // open-loop duty saturated to full scale
    always_comb
    begin
        priority if ($signed({open_reg[15], open_reg}) > DUTY_FULL)
        begin
            open_sat = DUTY_FULL[15:0];
        end
        else if ($signed({open_reg[15], open_reg}) < -DUTY_FULL)
        begin
            open_sat = 16'(-DUTY_FULL);
        end
        else
        begin
            open_sat = open_reg;
        end
    end

    // off-time share of the period for the driven bridge leg
    assign duty_ext = {duty_reg[15], duty_reg};
    assign comp_w   = duty_reg[15] ? (DUTY_FULL + duty_ext) : (DUTY_FULL - duty_ext);
    assign lvl_w    = prod_reg[DIV100_SHIFT +: 16];

    // config and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            kp_reg        <= 16'd459;
            ki_reg        <= 16'd1638;
            open_reg      <= '0;
            left_reg      <= 13'd5280;
            right_reg     <= 13'd480;
            stiff_reg     <= 8'd30;
            sum_reg       <= '0;
            step_reg      <= '0;
            seg_reg       <= '0;
            phase_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            held_duty_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // step test advance and end
            if (cmd.step_tick)
            begin
                step_reg <= step_reg + 1'b1;
                if (seg_reg == SEG_LAST)
                begin
                    seg_reg   <= '0;
                    phase_reg <= ~phase_reg;
                end
                else
                begin
                    seg_reg <= seg_reg + 1'b1;
                end
            end
            if (cmd.test_end)
            begin
                step_reg  <= '0;
                seg_reg   <= '0;
                phase_reg <= 1'b0;
                mode_reg  <= MODE_IDLE;
                fin_reg   <= 1'b1;
            end
            if (cmd.err_upd)
            begin
                sum_reg <= sum_sat;
            end
            // apply duty to the bridge levels
            if (cmd.lvl_set)
            begin
                held_duty_reg <= duty_reg;
                if (duty_reg[15])
                begin
                    held_a_reg <= lvl_w[12:0];
                    held_b_reg <= TOP16[12:0];
                end
                else
                begin
                    held_a_reg <= TOP16[12:0];
                    held_b_reg <= lvl_w[12:0];
                end
            end
            // result beat handshake
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // register writes
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MODE:
                    begin
                        mode_reg <= cfg_data[2:0];
                        if (cfg_data[2:0] == MODE_STEP)
                        begin
                            step_reg  <= '0;
                            seg_reg   <= '0;
                            phase_reg <= 1'b0;
                            sum_reg   <= '0;
                            fin_reg   <= 1'b0;
                        end
                    end
                    REG_KP:    kp_reg    <= cfg_data;
                    REG_KI:    ki_reg    <= cfg_data;
                    REG_OPEN:  open_reg  <= cfg_data;
                    REG_LEFT:  left_reg  <= cfg_data[12:0];
                    REG_RIGHT: right_reg <= cfg_data[12:0];
                    REG_STIFF: stiff_reg <= cfg_data[7:0];
                    default:   ;
                endcase
            end
        end
    end

    // working registers of the tick
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            supply_reg <= supply_sense;
            meas_reg   <= measured_current;
            angle_reg  <= shaft_angle;
        end
        if (cmd.check)
        begin
            fault_reg  <= fault_w;
            target_reg <= '0;
            pen_reg    <= pen_w;
        end
        if (cmd.step_tick)
        begin
            target_reg <= phase_reg ? TEST_AMPLITUDE : -TEST_AMPLITUDE;
        end
        if (cmd.wall_sat)
        begin
            target_reg <= wall_target;
        end
        if (cmd.err_upd)
        begin
            err_reg <= err_w;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p[47:0];
        end
        if (cmd.acc_load)
        begin
            acc_reg <= 42'(prod_reg);
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + 42'(prod_reg);
        end
        if (cmd.pi_round)
        begin
            neg_reg <= acc_reg[41];
            mag_reg <= (acc_reg[41] ? 42'(-acc_reg) : 42'(acc_reg)) + ROUND_HALF;
        end
        unique case (cmd.duty_sel)
            DUTY_KEEP: ;
            DUTY_ZERO: duty_reg <= '0;
            DUTY_OPEN: duty_reg <= open_sat;
            DUTY_PI:   duty_reg <= pi_duty;
            default:   ;
        endcase
        if (cmd.lvl_prep)
        begin
            comp_reg <= comp_w[14:0];
        end
        if (cmd.out_load)
        begin
            out_a_reg      <= held_a_reg;
            out_b_reg      <= held_b_reg;
            out_duty_reg   <= held_duty_reg;
            out_target_reg <= target_reg;
            out_fault_reg  <= fault_reg;
            out_done_reg   <= fin_reg;
        end
    end

    // status to the controller
    assign stat.fault     = fault_w;
    assign stat.mode      = mode_reg;
    assign stat.test_over = (step_reg >= TEST_END);
    assign stat.out_free  = ~out_valid_reg | out_ready;

    assign out_valid      = out_valid_reg;
    assign drive_level_a  = out_a_reg;
    assign drive_level_b  = out_b_reg;
    assign duty_command   = out_duty_reg;
    assign target_current = out_target_reg;
    assign fault          = out_fault_reg;
    assign sequence_done  = out_done_reg;

endmodule

[hdl/haptic_wall_current_pi_controller.sv]
// top level of the haptic wall current controller
//
//  channel   | dir | beat contents
//  ----------+-----+-------------------------------------------------------------
//  in_ch     | in  | supply_sense, measured_current, shaft_angle
//  out_ch    | out | drive_level_a/b, duty_command, target_current, fault, done
//  cfg_*     | in  | cfg_write, cfg_index, cfg_data (write only, no wait)
//
// the fault, idle and open-loop paths of a tick beat go straight to the level math, hold
// and step test end go straight to the output, the step test runs the pi math first and
// haptic mode adds the wall target before it, all through one shared multiplier
// reset clears the config to its defaults and the integral, counters and held
// levels to zero; no clearing pass is needed
// a finished result waits in the output register while the next beat is taken;
// a stalled output holds the sequencer only at its final write
module haptic_wall_current_pi_controller
    import hwc_pkg::*;
#(
    parameter int PWM_TOP        = 7500,
    parameter int TEST_LENGTH    = 400,
    parameter int SEGMENT_LENGTH = 100
)
(
    input  logic        clk,
    input  logic        rst_n,
    hwc_in_if.sink      in_ch,
    hwc_out_if.source   out_ch,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hwc_cmd_t  cmd;
    hwc_stat_t stat;

    // sequencer
    hwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    hwc_datapath #(
        .PWM_TOP        (PWM_TOP),
        .TEST_LENGTH    (TEST_LENGTH),
        .SEGMENT_LENGTH (SEGMENT_LENGTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .supply_sense     (in_ch.supply_sense),
        .measured_current (in_ch.measured_current),
        .shaft_angle      (in_ch.shaft_angle),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .drive_level_a    (out_ch.drive_level_a),
        .drive_level_b    (out_ch.drive_level_b),
        .duty_command     (out_ch.duty_command),
        .target_current   (out_ch.target_current),
        .fault            (out_ch.fault),
        .sequence_done    (out_ch.sequence_done)
    );

endmodule
